>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the paged bitset back end.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PBE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define PBE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `PBE_ASSERT_CLK(lbl, clk, rst, !(cond), msg)

`endif

>>> rtl/pbe_pkg.sv
// ----------------------------------------------------------------------------
// Paged bitset engine package
// Shared constants, opcodes and the classified command word.
// ----------------------------------------------------------------------------
`default_nettype none

package pbe_pkg;

  localparam int PAGE_WORD_SHIFT_DEF = 4;
  localparam int NUM_PAGES_DEF       = 64;
  localparam int IDX_W               = 16;
  localparam int CNT_W               = 17;
  localparam int OP_W                = 3;
  localparam int CHG_W               = 64;
  localparam int LAST_W              = 20;
  localparam int QUEUE_DEPTH         = 2;
  localparam int LIMIT_MAX           = 65536;

  localparam logic [OP_W-1:0] OP_SET_BIT   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLR_BIT   = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST_BIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_RANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLR_RANGE = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND_RUN  = 3'd5;

  typedef enum logic [2:0] {
    K_NOP,
    K_SETB,
    K_CLRB,
    K_SETR,
    K_CLRR,
    K_BUMP,
    K_FIND
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               err;
    logic               in_cap;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   lim;
    logic [LAST_W-1:0]  last_bit;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/pbe_if.sv
// ----------------------------------------------------------------------------
// Paged bitset engine channels
// Request and response handshake interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbe_in_if;
  import pbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] bit_index;
  logic [CNT_W-1:0] run_count;
  logic [CNT_W-1:0] search_limit;
  modport source (output valid, opcode, bit_index, run_count, search_limit, input ready);
  modport sink   (input valid, opcode, bit_index, run_count, search_limit, output ready);
endinterface

interface pbe_out_if;
  import pbe_pkg::*;
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             found;
  logic [IDX_W-1:0] found_index;
  logic             page_nonempty;
  logic [CHG_W-1:0] change_count;
  logic             status;
  modport source (output valid, bit_value, found, found_index, page_nonempty,
                  change_count, status, input ready);
  modport sink   (input valid, bit_value, found, found_index, page_nonempty,
                  change_count, status, output ready);
endinterface

`default_nettype wire

>>> rtl/paged_bitset_engine.sv
// ----------------------------------------------------------------------------
// Paged bitset engine
// Set/test bit: the word is read on pop, acted on in the first step and the result
// loaded into the output register in the done step; nothing is popped meanwhile or
// while the output stalls. Clear bit then rescans its page; ranges read and write
// each word, clear range then rescanning each touched page; find reads word by
// word, skipping all-zero or all-ones words whole, a mixed one bit by bit. Reset:
// a clearing pass zeroes every word; no request word is taken until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_bitset_engine #(
  parameter int PAGE_WORD_SHIFT = pbe_pkg::PAGE_WORD_SHIFT_DEF,
  parameter int NUM_PAGES       = pbe_pkg::NUM_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pbe_in_if.sink     req,
  pbe_out_if.source  rsp
);
  import pbe_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic pop;
  logic full;
  logic not_empty;
  logic clearing;

  pbe_front #(
    .PAGE_WORD_SHIFT(PAGE_WORD_SHIFT),
    .NUM_PAGES      (NUM_PAGES)
  ) u_front (
    .req     (req),
    .clearing(clearing),
    .full    (full),
    .push    (push),
    .cmd     (front_cmd)
  );

  pbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (front_cmd),
    .pop      (pop),
    .full     (full),
    .not_empty(not_empty),
    .rdata    (queue_cmd)
  );

  pbe_back #(
    .PAGE_WORD_SHIFT(PAGE_WORD_SHIFT),
    .NUM_PAGES      (NUM_PAGES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(not_empty),
    .cmd      (queue_cmd),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

>>> rtl/pbe_front.sv
// ----------------------------------------------------------------------------
// Paged bitset front end
// Accepts request words and classifies them against capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_front #(
  parameter int PAGE_WORD_SHIFT = pbe_pkg::PAGE_WORD_SHIFT_DEF,
  parameter int NUM_PAGES       = pbe_pkg::NUM_PAGES_DEF
) (
  pbe_in_if.sink          req,
  input  logic            clearing,
  input  logic            full,
  output logic            push,
  output pbe_pkg::cmd_t   cmd
);
  import pbe_pkg::*;

  localparam int CAP = NUM_PAGES * (2 ** PAGE_WORD_SHIFT) * 64;
  localparam int XW  = LAST_W + 1;
  localparam logic [XW-1:0] CAP_X = XW'(CAP);

  logic [XW-1:0]    idx_x;
  logic [XW-1:0]    end_x;
  logic [XW-1:0]    end_c;
  logic             in_cap;
  logic [CNT_W-1:0] lim_s;

  assign req.ready = !full && !clearing;
  assign push      = req.valid && req.ready;

  always_comb begin
    idx_x  = XW'(req.bit_index);
    end_x  = idx_x + XW'(req.run_count);
    end_c  = (end_x > CAP_X) ? CAP_X : end_x;
    in_cap = idx_x < CAP_X;
    lim_s  = (req.search_limit > CNT_W'(LIMIT_MAX)) ? CNT_W'(LIMIT_MAX) : req.search_limit;

    cmd          = '0;
    cmd.kind     = K_NOP;
    cmd.in_cap   = in_cap;
    cmd.idx      = req.bit_index;
    cmd.cnt      = req.run_count;
    cmd.lim      = lim_s;
    cmd.last_bit = end_x[LAST_W-1:0] - LAST_W'(1);
    case (req.opcode)
      OP_SET_BIT: begin
        if (in_cap) cmd.kind = K_SETB;
        else cmd.err = 1'b1;
      end
      OP_CLR_BIT: begin
        if (in_cap) cmd.kind = K_CLRB;
        else cmd.err = 1'b1;
      end
      OP_TEST_BIT: begin
        cmd.err = !in_cap;
      end
      OP_SET_RANGE: begin
        if (req.run_count != '0) begin
          if (end_x > CAP_X) cmd.err = 1'b1;
          else cmd.kind = K_SETR;
        end
      end
      OP_CLR_RANGE: begin
        if (req.run_count != '0) begin
          cmd.last_bit = end_c[LAST_W-1:0] - LAST_W'(1);
          if (idx_x < end_c) cmd.kind = K_CLRR;
          else cmd.kind = K_BUMP;
        end
      end
      OP_FIND_RUN: begin
        cmd.kind = K_FIND;
      end
      default: begin
        cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pbe_queue.sv
// ----------------------------------------------------------------------------
// Paged bitset command queue
// Short queue between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pbe_pkg::cmd_t wdata,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output pbe_pkg::cmd_t rdata
);
  import pbe_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;

  assign full      = fill == (AW+1)'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop) fill <= fill + (AW+1)'(1);
      else if (pop && !push) fill <= fill - (AW+1)'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/pbe_back.sv
// ----------------------------------------------------------------------------
// Paged bitset engine back end
// Word memory, page summary, change counter and the operation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pbe_back #(
  parameter int PAGE_WORD_SHIFT = pbe_pkg::PAGE_WORD_SHIFT_DEF,
  parameter int NUM_PAGES       = pbe_pkg::NUM_PAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  pbe_pkg::cmd_t cmd,
  output logic          pop,
  output logic          clearing,
  pbe_out_if.source     rsp
);
  import pbe_pkg::*;

  localparam int TW   = NUM_PAGES << PAGE_WORD_SHIFT;
  localparam int WAW  = (TW > 1) ? $clog2(TW) : 1;
  localparam int PGW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int PWW  = (PAGE_WORD_SHIFT > 0) ? PAGE_WORD_SHIFT : 1;
  localparam int SW   = WAW + PGW;
  localparam int FWW  = 11;
  localparam logic [PWW-1:0] WIP_LAST = PWW'((1 << PAGE_WORD_SHIFT) - 1);
  localparam logic [WAW-1:0] WORD_LAST = WAW'(TW - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIRST,
    S_RNG_RD,
    S_RNG_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIND_RD,
    S_FIND_LD,
    S_FIND_BIT,
    S_DONE
  } state_t;

  logic [63:0]     mem [TW];
  logic            we;
  logic [WAW-1:0]  wa;
  logic [63:0]     wd;
  logic            re;
  logic [WAW-1:0]  ra;
  logic [63:0]     rd;

  state_t          state;
  cmd_t            cur;
  logic [WAW-1:0]  clr_addr;
  logic [WAW-1:0]  word_ptr;
  logic [PGW-1:0]  pg;
  logic [PGW-1:0]  pg_last;
  logic [PWW-1:0]  wip;
  logic            nz;
  logic            old_bit;
  logic            find_hit;
  logic [IDX_W-1:0] find_at;
  logic            err;
  logic [NUM_PAGES-1:0] summary;
  logic [CHG_W-1:0] chg;
  logic [FWW-1:0]  fw;
  logic [5:0]      fb;
  logic [63:0]     fword;
  logic            fw_ok;
  logic [CNT_W-1:0] gap_start;
  logic [CNT_W:0]  run_len;

  logic [WAW-1:0]  idx_word;
  logic [WAW-1:0]  cmd_word;
  logic [WAW-1:0]  end_word;
  logic [PGW-1:0]  idx_pg;
  logic [5:0]      lo;
  logic [5:0]      hi;
  logic [63:0]     mask;
  logic [63:0]     bit_oh;
  logic [SW-1:0]   pg_sh;
  logic [WAW-1:0]  scan_addr;
  logic            bef;
  logic            nz_now;
  logic [CNT_W-1:0] base;
  logic [CNT_W:0]  base_end;
  logic [CNT_W-1:0] pos;
  logic            full_word;

  function automatic logic [PGW-1:0] word_page(input logic [WAW-1:0] w);
    return PGW'(w >> PAGE_WORD_SHIFT);
  endfunction

  always_comb begin
    idx_word  = WAW'(cur.idx >> 6);
    cmd_word  = WAW'(cmd.idx >> 6);
    end_word  = WAW'(cur.last_bit >> 6);
    idx_pg    = PGW'(cur.idx >> (6 + PAGE_WORD_SHIFT));
    lo        = (word_ptr == idx_word) ? cur.idx[5:0] : 6'd0;
    hi        = (word_ptr == end_word) ? cur.last_bit[5:0] : 6'd63;
    mask      = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
    bit_oh    = 64'd1 << cur.idx[5:0];
    pg_sh     = ({{WAW{1'b0}}, pg} << PAGE_WORD_SHIFT) | SW'(wip);
    scan_addr = pg_sh[WAW-1:0];
    bef       = cur.in_cap && rd[cur.idx[5:0]];
    nz_now    = nz || (rd != '0);
    base      = CNT_W'({fw, 6'd0});
    base_end  = {1'b0, base} + (CNT_W+1)'(64);
    pos       = CNT_W'({fw, fb});
    full_word = base_end <= {1'b0, cur.lim};

    we = 1'b0;
    wa = word_ptr;
    wd = '0;
    re = 1'b0;
    ra = word_ptr;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_addr;
      end
      S_IDLE: begin
        re = 1'b1;
        ra = cmd_word;
      end
      S_FIRST: begin
        wa = idx_word;
        if (cur.kind == K_SETB) begin
          we = 1'b1;
          wd = rd | bit_oh;
        end else if (cur.kind == K_CLRB) begin
          we = 1'b1;
          wd = rd & ~bit_oh;
        end
      end
      S_RNG_RD: re = 1'b1;
      S_RNG_WR: begin
        we = 1'b1;
        wd = (cur.kind == K_SETR) ? (rd | mask) : (rd & ~mask);
      end
      S_SCAN_RD: begin
        re = 1'b1;
        ra = scan_addr;
      end
      S_FIND_RD: begin
        re = 1'b1;
        ra = WAW'(fw);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd <= mem[ra];
  end

  assign clearing = state == S_CLEAR;
  assign pop      = (state == S_IDLE) && cmd_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      summary   <= '0;
      chg       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WAW'(1);
          if (clr_addr == WORD_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            cur   <= cmd;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          old_bit  <= bef;
          err      <= cur.err;
          find_hit <= 1'b0;
          find_at  <= '0;
          word_ptr <= idx_word;
          case (cur.kind)
            K_SETB: begin
              summary[idx_pg] <= 1'b1;
              if (!bef) chg <= chg + CHG_W'(1);
              state <= S_DONE;
            end
            K_CLRB: begin
              if (bef) chg <= chg + CHG_W'(1);
              pg      <= idx_pg;
              pg_last <= idx_pg;
              wip     <= '0;
              nz      <= 1'b0;
              state   <= S_SCAN_RD;
            end
            K_SETR, K_CLRR: state <= S_RNG_RD;
            K_BUMP: begin
              chg   <= chg + CHG_W'(1);
              state <= S_DONE;
            end
            K_FIND: begin
              fw        <= '0;
              gap_start <= '0;
              run_len   <= '0;
              if (cur.cnt == '0) begin
                find_hit <= 1'b1;
                state    <= S_DONE;
              end else begin
                state <= S_FIND_RD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_RNG_RD: state <= S_RNG_WR;
        S_RNG_WR: begin
          if (cur.kind == K_SETR) summary[word_page(word_ptr)] <= 1'b1;
          if (word_ptr == end_word) begin
            chg <= chg + CHG_W'(1);
            if (cur.kind == K_SETR) begin
              state <= S_DONE;
            end else begin
              pg      <= word_page(idx_word);
              pg_last <= word_page(end_word);
              wip     <= '0;
              nz      <= 1'b0;
              state   <= S_SCAN_RD;
            end
          end else begin
            word_ptr <= word_ptr + WAW'(1);
            state    <= S_RNG_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (wip == WIP_LAST) begin
            summary[pg] <= nz_now;
            nz          <= 1'b0;
            wip         <= '0;
            if (pg == pg_last) begin
              state <= S_DONE;
            end else begin
              pg    <= pg + PGW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            wip   <= wip + PWW'(1);
            nz    <= nz_now;
            state <= S_SCAN_RD;
          end
        end
        S_FIND_RD: begin
          fw_ok <= 32'(fw) < TW;
          if (base >= cur.lim) state <= S_DONE;
          else state <= S_FIND_LD;
        end
        S_FIND_LD: begin
          fword <= fw_ok ? rd : '0;
          fb    <= '0;
          state <= S_FIND_BIT;
        end
        S_FIND_BIT: begin
          if (pos >= cur.lim) begin
            state <= S_DONE;
          end else if (fb == '0 && full_word && fword == '0) begin
            if (run_len + (CNT_W+1)'(64) >= {1'b0, cur.cnt}) begin
              find_hit <= 1'b1;
              find_at  <= gap_start[IDX_W-1:0];
              state    <= S_DONE;
            end else begin
              run_len <= run_len + (CNT_W+1)'(64);
              fw      <= fw + FWW'(1);
              state   <= S_FIND_RD;
            end
          end else if (fb == '0 && full_word && (&fword)) begin
            gap_start <= base_end[CNT_W-1:0];
            run_len   <= '0;
            fw        <= fw + FWW'(1);
            state     <= S_FIND_RD;
          end else if (!fword[fb] && (run_len + (CNT_W+1)'(1) >= {1'b0, cur.cnt})) begin
            find_hit <= 1'b1;
            find_at  <= gap_start[IDX_W-1:0];
            state    <= S_DONE;
          end else begin
            if (fword[fb]) begin
              gap_start <= pos + CNT_W'(1);
              run_len   <= '0;
            end else begin
              run_len <= run_len + (CNT_W+1)'(1);
            end
            if (fb == 6'd63) begin
              fw    <= fw + FWW'(1);
              state <= S_FIND_RD;
            end else begin
              fb <= fb + 6'd1;
            end
          end
        end
        S_DONE: begin
          rsp.valid         <= 1'b1;
          rsp.bit_value     <= old_bit;
          rsp.found         <= find_hit;
          rsp.found_index   <= find_at;
          rsp.page_nonempty <= cur.in_cap && summary[idx_pg];
          rsp.change_count  <= chg;
          rsp.status        <= err;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PBE_ASSERT_CLK(a_chg_step, clk, rst, (!$past(rst) && chg != $past(chg)) |-> (chg == $past(chg) + CHG_W'(1)), "change counter moved by more than one")
  `PBE_ASSERT_CLK(a_pop_first, clk, rst, pop |=> (state == S_FIRST), "popped word not taken up")
  `PBE_ASSERT_NEVER(a_done_busy, clk, rst, (state == S_DONE) && rsp.valid && !rsp.ready, "result overwrites a waiting word")

endmodule

`default_nettype wire
